/* design/periodic_task_release_scheduler_core_defines.svh */
`ifndef PERIODIC_TASK_RELEASE_SCHEDULER_CORE_DEFINES_SVH
`define PERIODIC_TASK_RELEASE_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of aclk outside reset.
`define PTRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of aclk outside reset.
`define PTRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ptrs_pkg.sv */
`timescale 1ns / 1ps

package ptrs_pkg;

    localparam int MAX_TASKS_DEF    = 32;
    localparam int TIME_BITS_DEF    = 32;
    localparam int PRIO_BITS_DEF    = 8;
    localparam int PENDING_BITS_DEF = 16;

    typedef enum logic [1:0] {
        OP_CREATE   = 2'd0,
        OP_CHECK    = 2'd1,
        OP_DISPATCH = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_RUN,
        CS_HOLD
    } ctrl_state_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now;
        logic [31:0] period;
        logic [31:0] start_delay;
        logic [7:0]  priority_req;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] task_id;
        logic [5:0] releases_now;
    } out_item_t;

    // Control part of the operation token that walks the cell chain.
    typedef struct packed {
        logic active;
        op_t  op;
        logic claimed;
        logic found;
    } tok_ctl_t;

endpackage

/* design/ptrs_cell.sv */
`timescale 1ns / 1ps

module ptrs_cell import ptrs_pkg::*; #(
    parameter int IDX          = 0,
    parameter int TIME_BITS    = TIME_BITS_DEF,
    parameter int PRIO_BITS    = PRIO_BITS_DEF,
    parameter int PENDING_BITS = PENDING_BITS_DEF,
    parameter int ID_BITS      = 5,
    parameter int CNT_BITS     = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [TIME_BITS-1:0] now_i,
    input  logic [TIME_BITS-1:0] period_i,
    input  logic [TIME_BITS-1:0] delay_i,
    input  logic [PRIO_BITS-1:0] prio_i,
    input  logic                 dec_en_i,
    input  logic [ID_BITS-1:0]   dec_id_i,
    input  tok_ctl_t             tok_ctl_i,
    input  logic [ID_BITS-1:0]   tok_id_i,
    input  logic [CNT_BITS-1:0]  tok_cnt_i,
    input  logic [PRIO_BITS-1:0] tok_prio_i,
    output tok_ctl_t             tok_ctl_o,
    output logic [ID_BITS-1:0]   tok_id_o,
    output logic [CNT_BITS-1:0]  tok_cnt_o,
    output logic [PRIO_BITS-1:0] tok_prio_o
);

    logic                    valid_reg, valid_next;
    logic [TIME_BITS-1:0]    release_reg, release_next;
    logic [TIME_BITS-1:0]    period_reg, period_next;
    logic [PRIO_BITS-1:0]    prio_reg, prio_next;
    logic [PENDING_BITS-1:0] pend_reg, pend_next;

    tok_ctl_t                ctl_reg, ctl_next;
    logic [ID_BITS-1:0]      id_reg, id_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic [PRIO_BITS-1:0]    best_reg, best_next;

    always_comb begin
        valid_next   = valid_reg;
        release_next = release_reg;
        period_next  = period_reg;
        prio_next    = prio_reg;
        pend_next    = pend_reg;
        ctl_next     = tok_ctl_i;
        id_next      = tok_id_i;
        cnt_next     = tok_cnt_i;
        best_next    = tok_prio_i;

        if (tok_ctl_i.active) begin
            case (tok_ctl_i.op)
                OP_CREATE: begin
                    // The first free cell the token meets takes the new task.
                    if (!valid_reg && !tok_ctl_i.claimed) begin
                        valid_next       = 1'b1;
                        release_next     = now_i + delay_i;
                        period_next      = period_i;
                        prio_next        = prio_i;
                        pend_next        = '0;
                        ctl_next.claimed = 1'b1;
                        id_next          = ID_BITS'(IDX);
                    end
                end
                OP_CHECK: begin
                    if (valid_reg && (now_i >= release_reg)) begin
                        if (pend_reg != {PENDING_BITS{1'b1}}) begin
                            pend_next = pend_reg + PENDING_BITS'(1);
                        end
                        release_next = release_reg + period_reg;
                        cnt_next     = tok_cnt_i + CNT_BITS'(1);
                    end
                end
                OP_DISPATCH: begin
                    // Strict compare keeps the earlier slot on a tie.
                    if (valid_reg && (pend_reg != '0) &&
                        (!tok_ctl_i.found || (prio_reg < tok_prio_i))) begin
                        ctl_next.found = 1'b1;
                        id_next        = ID_BITS'(IDX);
                        best_next      = prio_reg;
                    end
                end
                default: begin
                end
            endcase
        end

        if (dec_en_i && (dec_id_i == ID_BITS'(IDX))) begin
            pend_next = pend_reg - PENDING_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            ctl_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            ctl_reg   <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        release_reg <= release_next;
        period_reg  <= period_next;
        prio_reg    <= prio_next;
        pend_reg    <= pend_next;
        id_reg      <= id_next;
        cnt_reg     <= cnt_next;
        best_reg    <= best_next;
    end

    assign tok_ctl_o  = ctl_reg;
    assign tok_id_o   = id_reg;
    assign tok_cnt_o  = cnt_reg;
    assign tok_prio_o = best_reg;

endmodule

/* design/ptrs_ctrl.sv */
`timescale 1ns / 1ps

module ptrs_ctrl import ptrs_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int PRIO_BITS = PRIO_BITS_DEF,
    parameter int ID_BITS   = 5,
    parameter int CNT_BITS  = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    output logic [TIME_BITS-1:0] now_o,
    output logic [TIME_BITS-1:0] period_o,
    output logic [TIME_BITS-1:0] delay_o,
    output logic [PRIO_BITS-1:0] prio_o,
    output tok_ctl_t             start_ctl_o,
    input  tok_ctl_t             last_ctl_i,
    input  logic [ID_BITS-1:0]   last_id_i,
    input  logic [CNT_BITS-1:0]  last_cnt_i,
    output logic                 dec_en_o,
    output logic [ID_BITS-1:0]   dec_id_o
);

    ctrl_state_t          state_reg, state_next;
    logic                 start_reg;
    op_t                  op_reg;
    logic [TIME_BITS-1:0] now_reg, period_reg, delay_reg;
    logic [PRIO_BITS-1:0] prio_reg;
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_data_reg, hold_reg;
    out_item_t            result;
    logic                 accept, out_free, load_result, load_hold, store_hold;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // The token only ever gains a slot number or a count on the operation
    // that reports it, so both pass straight into the result.
    always_comb begin
        result.task_id      = 5'(last_id_i);
        result.releases_now = 6'(last_cnt_i);
        result.status       = STATUS_OK;
        if (last_ctl_i.op == OP_CREATE && !last_ctl_i.claimed) begin
            result.status = STATUS_FULL;
        end else if (last_ctl_i.op == OP_DISPATCH && !last_ctl_i.found) begin
            result.status = STATUS_EMPTY;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        load_result = 1'b0;
        load_hold   = 1'b0;
        store_hold  = 1'b0;
        case (state_reg)
            CS_IDLE: begin
                s_ready = aresetn;
                if (s_valid) begin
                    state_next = CS_RUN;
                end
            end
            CS_RUN: begin
                if (last_ctl_i.active) begin
                    if (out_free) begin
                        load_result = 1'b1;
                        state_next  = CS_IDLE;
                    end else begin
                        store_hold = 1'b1;
                        state_next = CS_HOLD;
                    end
                end
            end
            CS_HOLD: begin
                if (out_free) begin
                    load_hold  = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg;
        if (load_result || load_hold) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= accept;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= op_t'(s_data.op);
            now_reg    <= TIME_BITS'(s_data.now);
            period_reg <= TIME_BITS'(s_data.period);
            delay_reg  <= TIME_BITS'(s_data.start_delay);
            prio_reg   <= PRIO_BITS'(s_data.priority_req);
        end
        if (store_hold) begin
            hold_reg <= result;
        end
        if (load_result) begin
            m_data_reg <= result;
        end else if (load_hold) begin
            m_data_reg <= hold_reg;
        end
    end

    assign now_o    = now_reg;
    assign period_o = period_reg;
    assign delay_o  = delay_reg;
    assign prio_o   = prio_reg;

    always_comb begin
        start_ctl_o         = '0;
        start_ctl_o.active  = start_reg;
        start_ctl_o.op      = op_reg;
    end

    // The chosen task gives up one pending release as the token leaves the chain.
    assign dec_en_o = last_ctl_i.active && (last_ctl_i.op == OP_DISPATCH) && last_ctl_i.found;
    assign dec_id_o = last_id_i;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* design/periodic_task_release_scheduler_core.sv */
`timescale 1ns / 1ps
// Fixed-priority periodic task table. Requests arrive on the s_ channel
// (s_valid, s_ready, s_data) and each one gives exactly one result transfer on
// the m_ channel (m_valid, m_ready, m_data). A request is create, check or
// dispatch; any other code answers status ok with zero fields.
// Each table slot is a cell in a chain of MAX_TASKS cells. A request becomes a
// token that moves one cell per cycle, so it passes every cell in turn; the
// result is registered into the output register once the token has left the
// last cell, and the next request can be taken once that result is loaded.
// One request is in the block at a time.
// If the receiver stalls, a finished result waits in a hold register behind the
// output register; s_ready stays low until the held result has moved on.
// Reset (aresetn low, synchronous) empties every slot and drops any request
// in flight; the per-slot stores are written when a slot is created.

`include "periodic_task_release_scheduler_core_defines.svh"

module periodic_task_release_scheduler_core import ptrs_pkg::*; #(
    parameter int MAX_TASKS    = MAX_TASKS_DEF,
    parameter int TIME_BITS    = TIME_BITS_DEF,
    parameter int PRIO_BITS    = PRIO_BITS_DEF,
    parameter int PENDING_BITS = PENDING_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int ID_BITS  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_BITS = $clog2(MAX_TASKS + 1);

    logic [TIME_BITS-1:0] now_w, period_w, delay_w;
    logic [PRIO_BITS-1:0] prio_w;
    logic                 dec_en;
    logic [ID_BITS-1:0]   dec_id;

    tok_ctl_t             chain_ctl  [0:MAX_TASKS];
    logic [ID_BITS-1:0]   chain_id   [0:MAX_TASKS];
    logic [CNT_BITS-1:0]  chain_cnt  [0:MAX_TASKS];
    logic [PRIO_BITS-1:0] chain_prio [0:MAX_TASKS];
    logic [MAX_TASKS:0]   chain_active;

    ptrs_ctrl #(
        .TIME_BITS (TIME_BITS),
        .PRIO_BITS (PRIO_BITS),
        .ID_BITS   (ID_BITS),
        .CNT_BITS  (CNT_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .now_o       (now_w),
        .period_o    (period_w),
        .delay_o     (delay_w),
        .prio_o      (prio_w),
        .start_ctl_o (chain_ctl[0]),
        .last_ctl_i  (chain_ctl[MAX_TASKS]),
        .last_id_i   (chain_id[MAX_TASKS]),
        .last_cnt_i  (chain_cnt[MAX_TASKS]),
        .dec_en_o    (dec_en),
        .dec_id_o    (dec_id)
    );

    assign chain_id[0]   = '0;
    assign chain_cnt[0]  = '0;
    assign chain_prio[0] = '0;

    for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
        ptrs_cell #(
            .IDX          (i),
            .TIME_BITS    (TIME_BITS),
            .PRIO_BITS    (PRIO_BITS),
            .PENDING_BITS (PENDING_BITS),
            .ID_BITS      (ID_BITS),
            .CNT_BITS     (CNT_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .now_i      (now_w),
            .period_i   (period_w),
            .delay_i    (delay_w),
            .prio_i     (prio_w),
            .dec_en_i   (dec_en),
            .dec_id_i   (dec_id),
            .tok_ctl_i  (chain_ctl[i]),
            .tok_id_i   (chain_id[i]),
            .tok_cnt_i  (chain_cnt[i]),
            .tok_prio_i (chain_prio[i]),
            .tok_ctl_o  (chain_ctl[i+1]),
            .tok_id_o   (chain_id[i+1]),
            .tok_cnt_o  (chain_cnt[i+1]),
            .tok_prio_o (chain_prio[i+1])
        );
    end

    for (genvar j = 0; j <= MAX_TASKS; j++) begin : g_active
        assign chain_active[j] = chain_ctl[j].active;
    end

    `PTRS_ASSERT_NOW(a_single_token, 1'b1, $onehot0(chain_active),
        "more than one request token in the cell chain")
    `PTRS_ASSERT_NEXT(a_start_token, s_valid && s_ready, chain_ctl[0].active && !s_ready,
        "accepted request did not enter the chain alone")
    `PTRS_ASSERT_NOW(a_dec_quiet, dec_en, !(|chain_active[MAX_TASKS-1:0]),
        "pending decrement while a token is still inside the chain")

endmodule
